// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/asp_pkg.sv
package asp_pkg;

    localparam int MAX_POINTS  = 1024;

    localparam int PT_W        = 24;
    localparam int DIR_W       = 18;
    localparam int TOL_W       = 32;
    localparam int PROD_W      = PT_W + DIR_W;
    localparam int SUP_W       = PROD_W + 1;
    localparam int CMP_W       = SUP_W + 2;
    localparam int SUM_W       = PT_W + $clog2(MAX_POINTS);
    localparam int SEEN_W      = $clog2(MAX_POINTS + 2);
    localparam int CNT_OUT_W   = 11;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STEP_W  = $clog2(SUM_W);
    localparam int LANES       = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIR_X         = 2'd0,
        REG_DIR_Y         = 2'd1,
        REG_DIR_Z         = 2'd2,
        REG_TIE_TOLERANCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [TOL_W-1:0]        tol;
    } cfg_t;

    // One finished set, handed from the accumulator to the divider.
    typedef struct packed {
        logic signed [SUP_W-1:0] best;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [SEEN_W-1:0]       count;
        logic                    ovf;
    } job_t;

endpackage

// File: hdl/asp_front.sv
module asp_front
    import asp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    push,
    output logic                    full,
    input  logic signed [PT_W-1:0]  pt_x,
    input  logic signed [PT_W-1:0]  pt_y,
    input  logic signed [PT_W-1:0]  pt_z,
    input  logic                    last_point,
    input  logic                    q_full,
    output logic                    job_push,
    output job_t                    job
);

    logic                     a_valid_reg;
    logic                     a_last_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;
    logic signed [PT_W-1:0]   ax_reg;
    logic signed [PT_W-1:0]   ay_reg;
    logic signed [PT_W-1:0]   az_reg;

    logic                     b_valid_reg;
    logic                     b_last_reg;
    logic signed [SUP_W-1:0]  dot_reg;
    logic signed [PT_W-1:0]   bx_reg;
    logic signed [PT_W-1:0]   by_reg;
    logic signed [PT_W-1:0]   bz_reg;

    logic signed [SUP_W-1:0]  best_reg;
    logic signed [SUP_W-1:0]  best_next;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [SUM_W-1:0]  sum_y_next;
    logic signed [SUM_W-1:0]  sum_z_reg;
    logic signed [SUM_W-1:0]  sum_z_next;
    logic [SEEN_W-1:0]        tied_reg;
    logic [SEEN_W-1:0]        tied_next;
    logic [SEEN_W-1:0]        seen_reg;
    logic [SEEN_W-1:0]        seen_next;
    logic                     empty_reg;
    logic                     empty_next;

    logic                     stall;
    logic                     accept;
    logic                     step;
    logic                     in_range;
    logic signed [CMP_W-1:0]  s_ext;
    logic signed [CMP_W-1:0]  best_ext;
    logic signed [CMP_W-1:0]  tol_ext;
    logic signed [CMP_W-1:0]  hi;
    logic signed [CMP_W-1:0]  lo;

    // The whole pipeline holds while a finished set cannot enter the queue.
    assign stall  = b_valid_reg & b_last_reg & q_full;
    assign full   = stall;
    assign accept = push & ~stall;
    assign step   = b_valid_reg & ~stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            if (accept)
            begin
                prod_x_reg <= pt_x * $signed(cfg.dir_x);
                prod_y_reg <= pt_y * $signed(cfg.dir_y);
                prod_z_reg <= pt_z * $signed(cfg.dir_z);
                ax_reg     <= pt_x;
                ay_reg     <= pt_y;
                az_reg     <= pt_z;
                a_last_reg <= last_point;
            end
            dot_reg    <= SUP_W'(prod_x_reg) + SUP_W'(prod_y_reg) + SUP_W'(prod_z_reg);
            bx_reg     <= ax_reg;
            by_reg     <= ay_reg;
            bz_reg     <= az_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign s_ext    = CMP_W'(dot_reg);
    assign best_ext = CMP_W'(best_reg);
    assign tol_ext  = $signed(CMP_W'(cfg.tol));
    assign hi       = best_ext + tol_ext;
    assign lo       = best_ext - tol_ext;
    assign in_range = seen_reg < SEEN_W'(MAX_POINTS);

    always_comb
    begin
        best_next  = best_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        tied_next  = tied_reg;
        seen_next  = seen_reg;
        empty_next = empty_reg;
        if (step)
        begin
            if (in_range)
            begin
                seen_next = seen_reg + 1'b1;
                if (empty_reg || (s_ext > hi))
                begin
                    best_next  = dot_reg;
                    sum_x_next = SUM_W'(bx_reg);
                    sum_y_next = SUM_W'(by_reg);
                    sum_z_next = SUM_W'(bz_reg);
                    tied_next  = SEEN_W'(1);
                    empty_next = 1'b0;
                end
                else if (s_ext >= lo)
                begin
                    sum_x_next = sum_x_reg + SUM_W'(bx_reg);
                    sum_y_next = sum_y_reg + SUM_W'(by_reg);
                    sum_z_next = sum_z_reg + SUM_W'(bz_reg);
                    tied_next  = tied_reg + 1'b1;
                end
            end
            else
            begin
                seen_next = SEEN_W'(MAX_POINTS + 1);
            end
        end
    end

    assign job_push  = step & b_last_reg;
    assign job.best  = best_next;
    assign job.sum_x = sum_x_next;
    assign job.sum_y = sum_y_next;
    assign job.sum_z = sum_z_next;
    assign job.count = tied_next;
    assign job.ovf   = seen_next > SEEN_W'(MAX_POINTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            tied_reg  <= '0;
            seen_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (job_push)
        begin
            best_reg  <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            tied_reg  <= '0;
            seen_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            best_reg  <= best_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            sum_z_reg <= sum_z_next;
            tied_reg  <= tied_next;
            seen_reg  <= seen_next;
            empty_reg <= empty_next;
        end
    end

endmodule

// File: hdl/asp_queue.sv
module asp_queue
    import asp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t rd_job,
    output logic empty
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// File: hdl/asp_back.sv
module asp_back
    import asp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  job_t                    job,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUP_W-1:0] support,
    output logic signed [PT_W-1:0]  avg_x,
    output logic signed [PT_W-1:0]  avg_y,
    output logic signed [PT_W-1:0]  avg_z,
    output logic [CNT_OUT_W-1:0]    tie_count,
    output logic                    overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIV_STEP_W-1:0]   step_reg;
    logic [DIV_STEP_W-1:0]   step_next;
    logic [SEEN_W-1:0]       div_reg;
    logic [SEEN_W-1:0]       div_next;
    logic [SUM_W-1:0]        quo_reg  [LANES];
    logic [SUM_W-1:0]        quo_next [LANES];
    logic [SEEN_W-1:0]       rem_reg  [LANES];
    logic [SEEN_W-1:0]       rem_next [LANES];
    logic                    neg_reg  [LANES];
    logic                    neg_next [LANES];
    logic signed [SUP_W-1:0] best_reg;
    logic signed [SUP_W-1:0] best_next;
    logic                    ovf_reg;
    logic                    ovf_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [SUP_W-1:0] support_reg;
    logic signed [SUP_W-1:0] support_next;
    logic signed [PT_W-1:0]  avg_reg  [LANES];
    logic signed [PT_W-1:0]  avg_next [LANES];
    logic [CNT_OUT_W-1:0]    tie_reg;
    logic [CNT_OUT_W-1:0]    tie_next;
    logic                    oflow_reg;
    logic                    oflow_next;

    logic signed [SUM_W-1:0]    sum_in  [LANES];
    logic [SEEN_W:0]            shifted [LANES];
    logic [SEEN_W:0]            diff    [LANES];
    logic                       ge      [LANES];
    logic [SUM_W-1:0]           signed_q [LANES];
    logic [SEEN_W+CNT_OUT_W-1:0] cnt_wide;
    logic                       out_free;

    assign sum_in[0] = job.sum_x;
    assign sum_in[1] = job.sum_y;
    assign sum_in[2] = job.sum_z;

    assign q_pop    = (state_reg == S_IDLE) & ~q_empty;
    assign out_free = ~out_valid_reg | pop;
    assign cnt_wide = {{CNT_OUT_W{1'b0}}, div_reg};

    // One quotient bit per lane per cycle, restoring division on magnitudes.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            shifted[i]  = {rem_reg[i], quo_reg[i][SUM_W-1]};
            ge[i]       = shifted[i] >= {1'b0, div_reg};
            diff[i]     = shifted[i] - {1'b0, div_reg};
            signed_q[i] = neg_reg[i] ? (~quo_reg[i] + 1'b1) : quo_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        div_next       = div_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~pop;
        support_next   = support_reg;
        tie_next       = tie_reg;
        oflow_next     = oflow_reg;
        for (int i = 0; i < LANES; i++)
        begin
            quo_next[i] = quo_reg[i];
            rem_next[i] = rem_reg[i];
            neg_next[i] = neg_reg[i];
            avg_next[i] = avg_reg[i];
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        neg_next[i] = sum_in[i][SUM_W-1];
                        quo_next[i] = sum_in[i][SUM_W-1] ? (~sum_in[i] + 1'b1) : sum_in[i];
                        rem_next[i] = '0;
                    end
                    div_next   = job.count;
                    best_next  = job.best;
                    ovf_next   = job.ovf;
                    step_next  = DIV_STEP_W'(SUM_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_next[i] = ge[i] ? diff[i][SEEN_W-1:0] : shifted[i][SEEN_W-1:0];
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], ge[i]};
                end
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    support_next   = best_reg;
                    tie_next       = cnt_wide[CNT_OUT_W-1:0];
                    oflow_next     = ovf_reg;
                    for (int i = 0; i < LANES; i++)
                    begin
                        avg_next[i] = signed_q[i][PT_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            div_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            support_reg   <= '0;
            tie_reg       <= '0;
            oflow_reg     <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                quo_reg[i] <= '0;
                rem_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
                avg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            div_reg       <= div_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            support_reg   <= support_next;
            tie_reg       <= tie_next;
            oflow_reg     <= oflow_next;
            for (int i = 0; i < LANES; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
                neg_reg[i] <= neg_next[i];
                avg_reg[i] <= avg_next[i];
            end
        end
    end

    assign empty     = ~out_valid_reg;
    assign support   = support_reg;
    assign avg_x     = avg_reg[0];
    assign avg_y     = avg_reg[1];
    assign avg_z     = avg_reg[2];
    assign tie_count = tie_reg;
    assign overflow  = oflow_reg;

endmodule

// File: hdl/average_support_point.sv
// Support point of a streamed convex vertex set along a programmable direction.
// Vertices enter at one per cycle while full is low: the dot product is taken in
// two registered stages, and the third stage compares it with the running maximum
// and adds the vertex into the tie group. A request flagged last_point hands the
// finished set to a two-entry queue and clears the accumulator, so the next set may
// follow at once. Each set is then loaded from the queue into the divider, which
// forms the three averages one quotient bit per cycle, and is moved into the output
// register once that is free. A last vertex that meets a full queue holds the input
// with full until the queue has room. Vertices beyond the 1024th of a set are
// dropped and raise overflow on its result.
// Write the direction and tolerance only while no set is in progress.
module average_support_point
    import asp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [CFG_IDX_W-1:0]    wr_index,
    input  logic [CFG_W-1:0]        wr_data,
    input  logic                    push,
    output logic                    full,
    input  logic signed [PT_W-1:0]  pt_x,
    input  logic signed [PT_W-1:0]  pt_y,
    input  logic signed [PT_W-1:0]  pt_z,
    input  logic                    last_point,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUP_W-1:0] support,
    output logic signed [PT_W-1:0]  avg_x,
    output logic signed [PT_W-1:0]  avg_y,
    output logic signed [PT_W-1:0]  avg_z,
    output logic [CNT_OUT_W-1:0]    tie_count,
    output logic                    overflow
);

    cfg_t cfg_reg;
    job_t front_job;
    job_t queue_job;
    logic job_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dir_x <= DIR_W'(65536);
            cfg_reg.dir_y <= '0;
            cfg_reg.dir_z <= '0;
            cfg_reg.tol   <= TOL_W'(4295);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DIR_X:         cfg_reg.dir_x <= wr_data[DIR_W-1:0];
                REG_DIR_Y:         cfg_reg.dir_y <= wr_data[DIR_W-1:0];
                REG_DIR_Z:         cfg_reg.dir_z <= wr_data[DIR_W-1:0];
                REG_TIE_TOLERANCE: cfg_reg.tol   <= wr_data[TOL_W-1:0];
                default:           cfg_reg       <= cfg_reg;
            endcase
        end
    end

    asp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_z       (pt_z),
        .last_point (last_point),
        .q_full     (q_full),
        .job_push   (job_push),
        .job        (front_job)
    );

    asp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (front_job),
        .full   (q_full),
        .pop    (q_pop),
        .rd_job (queue_job),
        .empty  (q_empty)
    );

    asp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .job       (queue_job),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .support   (support),
        .avg_x     (avg_x),
        .avg_y     (avg_y),
        .avg_z     (avg_z),
        .tie_count (tie_count),
        .overflow  (overflow)
    );

endmodule

// File: hdl/asp_checker.sv
`include "assert_macros.svh"

module asp_checker
    import asp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    push,
    input logic                    full,
    input logic                    last_point,
    input logic                    empty,
    input logic                    pop,
    input logic signed [SUP_W-1:0] support,
    input logic [CNT_OUT_W-1:0]    tie_count
);

    // Sets whose last vertex has been taken but whose result is not yet taken.
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       set_in;
    logic       result_out;

    assign set_in     = push & ~full & last_point;
    assign result_out = pop & ~empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (set_in && !result_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_out && !set_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASP_ASSERT_IMPLIES(a_result_has_ties, clk, rst_n, !empty, tie_count != '0,
        "result shows a tie count of zero")

    `ASP_ASSERT_IMPLIES(a_result_has_set, clk, rst_n, !empty, pending_reg != '0,
        "result offered without a finished set")

    `ASP_ASSERT_IMPLIES(a_full_has_set, clk, rst_n, full, pending_reg != '0,
        "input held off with no finished set waiting")

    `ASP_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(support) && $stable(tie_count),
        "waiting result changed before it was taken")

endmodule

bind average_support_point asp_checker u_asp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .last_point (last_point),
    .empty      (empty),
    .pop        (pop),
    .support    (support),
    .tie_count  (tie_count)
);
